### sv/prb_pkg.sv
// Package: shared types, codes and defaults for the packet reorder buffer.
`default_nettype none
package prb_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_ENTRIES_DEF = 32;
  localparam int HANDLE_BITS_DEF = 8;

  // Fixed field widths
  localparam int SEQ_W    = 32;
  localparam int LEN_W    = 10;
  localparam int HDL_W    = 8;
  localparam int CNT_W    = 6;
  localparam int CAP_W    = 6;
  localparam int KIND_W   = 2;
  localparam int STS_W    = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // Command codes
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENTRY   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

  // Store status codes
  localparam logic [STS_W-1:0] STS_STORED = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL   = 2'd1;
  localparam logic [STS_W-1:0] STS_DUP    = 2'd2;

  typedef struct packed {
    logic              command;
    logic [SEQ_W-1:0]  seq_number;
    logic [LEN_W-1:0]  payload_length;
    logic [HDL_W-1:0]  payload_handle;
    logic [SEQ_W-1:0]  expected_in;
  } prb_in_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [STS_W-1:0]  store_status;
    logic [SEQ_W-1:0]  out_seq;
    logic [LEN_W-1:0]  out_length;
    logic [HDL_W-1:0]  out_handle;
    logic [CNT_W-1:0]  flushed_count;
    logic [SEQ_W-1:0]  expected_out;
    logic              is_full;
    logic              last;
  } prb_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              latch;
    logic              scan_start;
    logic              store_write;
    logic              take;
    logic              load;
    logic [KIND_W-1:0] kind;
    logic [STS_W-1:0]  status;
    logic              last;
  } prb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_flush;
    logic full;
    logic hit;
    logic scan_done;
    logic out_free;
  } prb_sts_t;

endpackage
`default_nettype wire

### sv/prb_datapath.sv
// Datapath: descriptor memory, valid bits, sequential match scan and output register.
`default_nettype none
module prb_datapath #(
  parameter int MAX_ENTRIES = prb_pkg::MAX_ENTRIES_DEF,
  parameter int HANDLE_BITS = prb_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire prb_pkg::prb_in_t          in_data,
  input  wire logic                      cfg_wr_en,
  input  wire logic [prb_pkg::CAP_W-1:0] cfg_wr_data,
  input  wire prb_pkg::prb_cmd_t         cmd,
  output prb_pkg::prb_sts_t              sts,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output prb_pkg::prb_out_t              out_data
);
  import prb_pkg::*;

  localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int HCW = $clog2(MAX_ENTRIES + 1);
  localparam int CW  = 7;
  localparam int EW  = SEQ_W + LEN_W + HANDLE_BITS;
  localparam logic [IW-1:0]  LAST_IDX = IW'(MAX_ENTRIES - 1);
  localparam logic [CW-1:0]  MAX_CW   = CW'(MAX_ENTRIES);

  // Request registers
  logic                   flush_r;
  logic [SEQ_W-1:0]       key_r;
  logic [LEN_W-1:0]       len_r;
  logic [HANDLE_BITS-1:0] hdl_r;
  logic [CNT_W-1:0]       count_r;

  // Capacity register and fill state
  logic [CAP_W-1:0]       cap_r;
  logic [HCW-1:0]         held_r, held_nxt;
  logic [MAX_ENTRIES-1:0] valid_r;

  // Scan state
  logic                   rd_act_r, cmp_act_r;
  logic [IW-1:0]          rd_ptr_r, cmp_idx_r;
  logic [EW-1:0]          rd_data_r;
  logic                   hit_r, free_ok_r;
  logic [IW-1:0]          hit_idx_r, free_idx_r;
  logic [LEN_W-1:0]       hit_len_r;
  logic [HANDLE_BITS-1:0] hit_hdl_r;

  // Output register
  logic                   out_valid_r;
  prb_out_t               out_r, out_nxt;

  logic [EW-1:0]          mem [MAX_ENTRIES];

  logic [SEQ_W-1:0]       rd_seq;
  logic [LEN_W-1:0]       rd_len;
  logic [HANDLE_BITS-1:0] rd_hdl;
  logic                   ent_v;
  logic [CW-1:0]          eff_lim;
  logic                   out_free;

  assign rd_seq = rd_data_r[EW-1 -: SEQ_W];
  assign rd_len = rd_data_r[HANDLE_BITS +: LEN_W];
  assign rd_hdl = rd_data_r[HANDLE_BITS-1:0];
  assign ent_v  = valid_r[cmp_idx_r];

  // Effective limit is the smaller of the register and the store size
  assign eff_lim  = (CW'(cap_r) < MAX_CW) ? CW'(cap_r) : MAX_CW;
  assign out_free = !out_valid_r || !out_stall;

  // Held count after the action of this cycle
  always_comb begin
    held_nxt = held_r;
    if (cmd.store_write) begin
      held_nxt = held_r + HCW'(1);
    end else if (cmd.take) begin
      held_nxt = held_r - HCW'(1);
    end
  end

  assign sts.is_flush  = flush_r;
  assign sts.full      = CW'(held_r) >= eff_lim;
  assign sts.hit       = hit_r;
  assign sts.scan_done = cmp_act_r && (cmp_idx_r == LAST_IDX);
  assign sts.out_free  = out_free;

  // Descriptor memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store_write) begin
      mem[free_idx_r] <= {key_r, len_r, hdl_r};
    end
    if (rd_act_r) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  // Latch the request; advance the key and count per flushed entry
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      flush_r <= in_data.command;
      key_r   <= (in_data.command == CMD_FLUSH) ? in_data.expected_in
                                                : in_data.seq_number;
      len_r   <= in_data.payload_length;
      hdl_r   <= HANDLE_BITS'(in_data.payload_handle);
      count_r <= '0;
    end else if (cmd.take) begin
      key_r   <= key_r + SEQ_W'(1);
      count_r <= count_r + CNT_W'(1);
    end
  end

  // Capacity, held count and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      held_r  <= '0;
      valid_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      held_r <= held_nxt;
      if (cmd.store_write) begin
        valid_r[free_idx_r] <= 1'b1;
      end else if (cmd.take) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
    end
  end

  // Scan control: issue one read per cycle, compare each entry in the cycle after its read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_act_r  <= 1'b0;
      cmp_act_r <= 1'b0;
      rd_ptr_r  <= '0;
      hit_r     <= 1'b0;
      free_ok_r <= 1'b0;
    end else begin
      cmp_act_r <= rd_act_r;
      if (cmd.scan_start) begin
        rd_act_r  <= 1'b1;
        rd_ptr_r  <= '0;
        hit_r     <= 1'b0;
        free_ok_r <= 1'b0;
      end else begin
        if (rd_act_r) begin
          rd_ptr_r <= rd_ptr_r + IW'(1);
          if (rd_ptr_r == LAST_IDX) begin
            rd_act_r <= 1'b0;
          end
        end
        if (cmp_act_r && ent_v && (rd_seq == key_r)) begin
          hit_r <= 1'b1;
        end
        if (cmp_act_r && !ent_v && !free_ok_r) begin
          free_ok_r <= 1'b1;
        end
      end
    end
  end

  // Capture the matching entry and the first free slot
  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_ptr_r;
    if (cmp_act_r && ent_v && (rd_seq == key_r)) begin
      hit_idx_r <= cmp_idx_r;
      hit_len_r <= rd_len;
      hit_hdl_r <= rd_hdl;
    end
    if (cmp_act_r && !ent_v && !free_ok_r) begin
      free_idx_r <= cmp_idx_r;
    end
  end

  // Assemble the result beat
  always_comb begin
    out_nxt               = '0;
    out_nxt.result_kind   = cmd.kind;
    out_nxt.last          = cmd.last;
    out_nxt.is_full       = CW'(held_nxt) >= eff_lim;
    case (cmd.kind)
      KIND_STATUS: begin
        out_nxt.store_status = cmd.status;
      end
      KIND_ENTRY: begin
        out_nxt.out_seq    = key_r;
        out_nxt.out_length = hit_len_r;
        out_nxt.out_handle = HDL_W'(hit_hdl_r);
      end
      KIND_SUMMARY: begin
        out_nxt.flushed_count = count_r;
        out_nxt.expected_out  = key_r;
      end
      default: begin
        out_nxt.result_kind = cmd.kind;
      end
    endcase
  end

  // Output register: hold while stalled, load a new beat when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### sv/prb_ctrl.sv
// Controller: sequences accept, scan and decision for store and flush requests.
`default_nettype none
module prb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire prb_pkg::prb_sts_t sts,
  output prb_pkg::prb_cmd_t      cmd
);
  import prb_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      // Take a request and start the first scan
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch      = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_DECIDE;
        end
      end
      // Act on the scan result once the output register can take a beat
      S_DECIDE: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (!sts.is_flush) begin
            cmd.kind = KIND_STATUS;
            cmd.last = 1'b1;
            if (sts.full) begin
              cmd.status = STS_FULL;
            end else if (sts.hit) begin
              cmd.status = STS_DUP;
            end else begin
              cmd.status      = STS_STORED;
              cmd.store_write = 1'b1;
            end
            state_nxt = S_IDLE;
          end else if (sts.hit) begin
            cmd.kind       = KIND_ENTRY;
            cmd.take       = 1'b1;
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            cmd.kind  = KIND_SUMMARY;
            cmd.last  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/packet_reorder_buffer.sv
// Top level: receive-side packet reorder buffer, controller plus datapath.
//
// Input channel (in_valid/in_stall/in_data) takes one request beat: a store of a
// packet descriptor or a flush from an expected sequence number. The result
// channel (out_valid/out_stall/out_data) returns one status beat per store, and
// per flush one beat per in-order entry released followed by a summary beat;
// the last beat of each request has last set.
// Each lookup scans the descriptor memory one entry per cycle through its single
// read port; a flush scans once more for each entry it releases, and its summary
// beat follows the first scan that finds no match for the expected number.
// One request is worked on at a time; the next is accepted from the cycle in
// which the previous result beat sits in the output register, even while that
// beat is still stalled. A stalled output holds its beat; the block waits before
// loading the next. cfg_wr_en/cfg_wr_data set the capacity limit (reset value
// 32); the user must write it only while idle, which the block itself does not
// enforce. Reset (rst_n low, synchronous) empties the buffer at once.
`default_nettype none
module packet_reorder_buffer #(
  parameter int MAX_ENTRIES = prb_pkg::MAX_ENTRIES_DEF,
  parameter int HANDLE_BITS = prb_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire prb_pkg::prb_in_t          in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output prb_pkg::prb_out_t              out_data,
  input  wire logic                      cfg_wr_en,
  input  wire logic [prb_pkg::CAP_W-1:0] cfg_wr_data
);
  import prb_pkg::*;

  prb_cmd_t cmd;
  prb_sts_t sts;

  prb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  prb_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire
